// ===== hw/rtl/frat_pkg.sv =====
// shared types and constants of the frequency ranked address table
`timescale 1ns / 1ps
`default_nettype none

package frat_pkg;

    // fixed field widths
    localparam int ADDR_W     = 16;
    localparam int OUT_HITS_W = 16;
    localparam int CMD_W      = 2;
    localparam int TOPC_W     = 6;
    localparam int STATUS_W   = 2;
    localparam int RANK_W     = 5;

    // most results one read command returns
    localparam int MAX_RESULTS = 32;

    // parameter defaults
    localparam int MAX_ENTRIES_DEF = 32;
    localparam int HIT_BITS_DEF    = 16;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TOP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_BUBBLE,
        ST_WRITE,
        ST_EMIT,
        ST_READ
    } state_t;

    // compare unit flags
    typedef struct packed {
        logic addr_eq;
        logic ranks_below;
    } cmp_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/frat_if.sv =====
// request and response channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface frat_req_if;
    import frat_pkg::*;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] node_address;
    logic [TOPC_W-1:0] top_count;

    modport source (output valid, cmd, node_address, top_count, input ready);
    modport sink   (input valid, cmd, node_address, top_count, output ready);
endinterface

interface frat_rsp_if;
    import frat_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [ADDR_W-1:0]     out_address;
    logic [OUT_HITS_W-1:0] out_hits;
    logic [RANK_W-1:0]     rank;
    logic                  last;

    modport source (output valid, status, out_address, out_hits, rank, last, input ready);
    modport sink   (input valid, status, out_address, out_hits, rank, last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/frequency_ranked_address_table.sv =====
// top level of the frequency ranked address table
`timescale 1ns / 1ps
`default_nettype none

// Frequency ranked address table. Holds up to MAX_ENTRIES distinct 16-bit
// node addresses with saturating hit counts, kept sorted by count descending
// and address ascending on ties. Commands arrive on req: increment an
// address, read the leading top_count entries, or clear. Results leave on
// rsp through an output register, with last set on the final item of each
// command; clear and unused codes give no item. An increment walks the
// table from rank 0, one entry per cycle through the single ram read port
// and the shared compare unit, until it finds the address or reaches the
// end; a new address on a full table is dropped with a full status. Else
// it walks back toward the front one entry per cycle while the moved entry
// outranks its predecessor, writes the key into its slot, and loads the
// result into the output register once that is free. A read waits for
// the registered ram output and then streams one item per cycle while rsp
// is ready. The table is tracked by a fill count, so there is no clearing
// pass after reset and the block is ready right away. req is ready only
// between commands.

module frequency_ranked_address_table #(
    parameter int MAX_ENTRIES = frat_pkg::MAX_ENTRIES_DEF,
    parameter int HIT_BITS    = frat_pkg::HIT_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    frat_req_if.sink   req,
    frat_rsp_if.source rsp
);
    import frat_pkg::*;

    localparam int IDX_W  = $clog2(MAX_ENTRIES);
    localparam int WORD_W = ADDR_W + HIT_BITS;

    // ram word: address in the upper bits, hit count in the lower bits
    logic [IDX_W-1:0]    rd_addr;
    logic [WORD_W-1:0]   rd_data;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [WORD_W-1:0]   wr_data;

    // key the shared compare unit tests each stored entry against
    logic [ADDR_W-1:0]   key_addr;
    logic [HIT_BITS-1:0] key_hits;
    cmp_res_t            cmp;

    // sequencer: find, reinsertion walk, read-out, output register
    frat_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .HIT_BITS    (HIT_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .key_addr (key_addr),
        .key_hits (key_hits),
        .cmp      (cmp)
    );

    // sorted table storage
    frat_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // compare unit on the registered ram output
    frat_cmp #(
        .HIT_BITS (HIT_BITS)
    ) u_cmp (
        .entry    (rd_data),
        .key_addr (key_addr),
        .key_hits (key_hits),
        .res      (cmp)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/frat_ram.sv =====
// generic single write, single read ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module frat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/frat_cmp.sv =====
// shared compare unit: address match and rank order against a key
`timescale 1ns / 1ps
`default_nettype none

module frat_cmp #(
    parameter int HIT_BITS = frat_pkg::HIT_BITS_DEF
) (
    input  wire logic [frat_pkg::ADDR_W+HIT_BITS-1:0] entry,
    input  wire logic [frat_pkg::ADDR_W-1:0]          key_addr,
    input  wire logic [HIT_BITS-1:0]                  key_hits,
    output      frat_pkg::cmp_res_t                   res
);
    import frat_pkg::*;

    logic [ADDR_W-1:0]   e_addr;
    logic [HIT_BITS-1:0] e_hits;

    assign e_addr = entry[ADDR_W+HIT_BITS-1 -: ADDR_W];
    assign e_hits = entry[HIT_BITS-1:0];

    always_comb
    begin
        res.addr_eq     = (e_addr == key_addr);
        // lower count, or same count and higher address
        res.ranks_below = (e_hits < key_hits) ||
                          ((e_hits == key_hits) && (e_addr > key_addr));
    end

endmodule

`default_nettype wire

// ===== hw/rtl/frat_ctrl.sv =====
// sequencer: lookup, reinsertion, read-out and the output register
`timescale 1ns / 1ps
`default_nettype none

module frat_ctrl #(
    parameter int MAX_ENTRIES = frat_pkg::MAX_ENTRIES_DEF,
    parameter int HIT_BITS    = frat_pkg::HIT_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    frat_req_if.sink                                  req,
    frat_rsp_if.source                                rsp,
    output      logic [$clog2(MAX_ENTRIES)-1:0]       rd_addr,
    input  wire logic [frat_pkg::ADDR_W+HIT_BITS-1:0] rd_data,
    output      logic                                 wr_en,
    output      logic [$clog2(MAX_ENTRIES)-1:0]       wr_addr,
    output      logic [frat_pkg::ADDR_W+HIT_BITS-1:0] wr_data,
    output      logic [frat_pkg::ADDR_W-1:0]          key_addr,
    output      logic [HIT_BITS-1:0]                  key_hits,
    input  wire frat_pkg::cmp_res_t                   cmp
);
    import frat_pkg::*;

    localparam int IDX_W  = $clog2(MAX_ENTRIES);
    localparam int TOT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int NW     = (TOT_W > TOPC_W) ? TOT_W : TOPC_W;
    localparam logic [HIT_BITS-1:0] HIT_MAX = {HIT_BITS{1'b1}};

    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      scan_reg, scan_next;
    logic [IDX_W-1:0]      pos_reg, pos_next;
    logic [IDX_W-1:0]      last_idx_reg, last_idx_next;
    logic [TOT_W-1:0]      total_reg, total_next;
    logic [ADDR_W-1:0]     key_addr_reg, key_addr_next;
    logic [HIT_BITS-1:0]   key_hits_reg, key_hits_next;
    logic [STATUS_W-1:0]   status_reg, status_next;

    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [ADDR_W-1:0]     out_addr_reg, out_addr_next;
    logic [OUT_HITS_W-1:0] out_hits_reg, out_hits_next;
    logic [RANK_W-1:0]     out_rank_reg, out_rank_next;
    logic                  out_last_reg, out_last_next;

    logic                  slot_free;
    logic [ADDR_W-1:0]     e_addr;
    logic [HIT_BITS-1:0]   e_hits;
    logic [HIT_BITS-1:0]   e_hits_inc;
    logic [NW-1:0]         n_run;
    logic [NW-1:0]         n_run_m1;
    logic [OUT_HITS_W+HIT_BITS-1:0] key_hits_ext;
    logic [OUT_HITS_W+HIT_BITS-1:0] e_hits_ext;
    logic [RANK_W+IDX_W-1:0]        pos_ext;
    logic [RANK_W+IDX_W-1:0]        scan_ext;

    assign e_addr     = rd_data[ADDR_W+HIT_BITS-1 -: ADDR_W];
    assign e_hits     = rd_data[HIT_BITS-1:0];
    assign e_hits_inc = (e_hits == HIT_MAX) ? e_hits : e_hits + HIT_BITS'(1);
    assign slot_free  = !out_valid_reg || rsp.ready;

    // counts and positions are zero-extended; their low bits go to the output fields
    assign key_hits_ext = {{OUT_HITS_W{1'b0}}, key_hits_reg};
    assign e_hits_ext   = {{OUT_HITS_W{1'b0}}, e_hits};
    assign pos_ext      = {{RANK_W{1'b0}}, pos_reg};
    assign scan_ext     = {{RANK_W{1'b0}}, scan_reg};

    // length of a read run
    always_comb
    begin
        n_run = NW'(req.top_count);
        if (NW'(total_reg) < n_run)
        begin
            n_run = NW'(total_reg);
        end
        if (n_run > NW'(MAX_RESULTS))
        begin
            n_run = NW'(MAX_RESULTS);
        end
        n_run_m1 = n_run - NW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg       <= scan_next;
        pos_reg        <= pos_next;
        last_idx_reg   <= last_idx_next;
        key_addr_reg   <= key_addr_next;
        key_hits_reg   <= key_hits_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
        out_hits_reg   <= out_hits_next;
        out_rank_reg   <= out_rank_next;
        out_last_reg   <= out_last_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        scan_next       = scan_reg;
        pos_next        = pos_reg;
        last_idx_next   = last_idx_reg;
        total_next      = total_reg;
        key_addr_next   = key_addr_reg;
        key_hits_next   = key_hits_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        out_hits_next   = out_hits_reg;
        out_rank_next   = out_rank_reg;
        out_last_next   = out_last_reg;
        rd_addr         = scan_reg;
        wr_en           = 1'b0;
        wr_addr         = pos_reg;
        wr_data         = {key_addr_reg, key_hits_reg};
        req.ready       = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    case (req.cmd)
                        CMD_INC:
                        begin
                            key_addr_next = req.node_address;
                            status_next   = STAT_OK;
                            scan_next     = '0;
                            rd_addr       = '0;
                            if (total_reg == '0)
                            begin
                                pos_next      = '0;
                                key_hits_next = HIT_BITS'(1);
                                total_next    = TOT_W'(1);
                                state_next    = ST_WRITE;
                            end
                            else
                            begin
                                state_next = ST_FIND;
                            end
                        end
                        CMD_TOP:
                        begin
                            scan_next = '0;
                            rd_addr   = '0;
                            if (n_run == '0)
                            begin
                                status_next   = STAT_EMPTY;
                                key_addr_next = '0;
                                key_hits_next = '0;
                                pos_next      = '0;
                                state_next    = ST_EMIT;
                            end
                            else
                            begin
                                last_idx_next = n_run_m1[IDX_W-1:0];
                                state_next    = ST_READ;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            total_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // one stored entry compared per cycle
            ST_FIND:
            begin
                if (cmp.addr_eq)
                begin
                    key_hits_next = e_hits_inc;
                    pos_next      = scan_reg;
                    if (scan_reg == '0)
                    begin
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        rd_addr    = scan_reg - IDX_W'(1);
                        state_next = ST_BUBBLE;
                    end
                end
                else if (TOT_W'(scan_reg) + TOT_W'(1) == total_reg)
                begin
                    if (total_reg == TOT_W'(MAX_ENTRIES))
                    begin
                        status_next   = STAT_FULL;
                        key_hits_next = '0;
                        pos_next      = '0;
                        state_next    = ST_EMIT;
                    end
                    else
                    begin
                        key_hits_next = HIT_BITS'(1);
                        pos_next      = total_reg[IDX_W-1:0];
                        total_next    = total_reg + TOT_W'(1);
                        rd_addr       = total_reg[IDX_W-1:0] - IDX_W'(1);
                        state_next    = ST_BUBBLE;
                    end
                end
                else
                begin
                    scan_next = scan_reg + IDX_W'(1);
                    rd_addr   = scan_reg + IDX_W'(1);
                end
            end

            // predecessor in rd_data, shift it down while it ranks below the key
            ST_BUBBLE:
            begin
                if (cmp.ranks_below)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = pos_reg;
                    wr_data  = rd_data;
                    pos_next = pos_reg - IDX_W'(1);
                    if (pos_reg == IDX_W'(1))
                    begin
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        rd_addr = pos_reg - IDX_W'(2);
                    end
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end

            ST_WRITE:
            begin
                wr_en      = 1'b1;
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_addr_next   = key_addr_reg;
                    out_hits_next   = key_hits_ext[OUT_HITS_W-1:0];
                    out_rank_next   = pos_ext[RANK_W-1:0];
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            // rd_data holds entry scan_reg; a stall keeps rereading it
            ST_READ:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_OK;
                    out_addr_next   = e_addr;
                    out_hits_next   = e_hits_ext[OUT_HITS_W-1:0];
                    out_rank_next   = scan_ext[RANK_W-1:0];
                    out_last_next   = (scan_reg == last_idx_reg);
                    if (scan_reg == last_idx_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        scan_next = scan_reg + IDX_W'(1);
                        rd_addr   = scan_reg + IDX_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign key_addr        = key_addr_reg;
    assign key_hits        = key_hits_reg;
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.out_address = out_addr_reg;
    assign rsp.out_hits    = out_hits_reg;
    assign rsp.rank        = out_rank_reg;
    assign rsp.last        = out_last_reg;

endmodule

`default_nettype wire

// ===== verif/tb_frequency_ranked_address_table.sv =====
// testbench for the frequency ranked address table: own ranking predictor, random handshakes
`timescale 1ns / 1ps

module tb_frequency_ranked_address_table;

    import frat_pkg::*;

    // table geometry as built into the default block
    localparam int          TABLE_DEPTH = MAX_ENTRIES_DEF;
    localparam int unsigned HIT_MAX     = (1 << HIT_BITS_DEF) - 1;

    // command code the block ignores
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // idle chance per cycle, in percent, on either side
    localparam int IDLE_PCT = 29;
    // length of the forced hold-off on the response side
    localparam int HOLD_CYCLES = 300;
    // worst-case increment latency plus margin
    localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 40;
    localparam int RANDOM_ITEMS = 500;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [ADDR_W-1:0]     address;
        logic [OUT_HITS_W-1:0] hits;
        logic [RANK_W-1:0]     rank;
        logic                  last;
    } ranked_row_t;

    // one row of the directed stimulus table
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] address;
        logic [TOPC_W-1:0] top_count;
        logic              typed;
        ranked_row_t       row;
    } directed_row_t;

    localparam int N_DIRECTED = 18;

    logic clk;
    logic rst_n;

    frat_req_if req_ch ();
    frat_rsp_if rsp_ch ();

    frequency_ranked_address_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // predictor copy of the sorted table
    logic [ADDR_W-1:0] ranked_addr [TABLE_DEPTH];
    int unsigned       ranked_hits [TABLE_DEPTH];
    int                ranked_fill;

    // results still owed by the block, oldest first
    ranked_row_t awaited_rows [$];

    int  mismatches;
    int  items_sent;
    int  rows_checked;
    int  drops_seen;
    int  peak_hits;
    bit  calm;
    int  hold_asks;

    directed_row_t directed_rows [N_DIRECTED];

    function automatic ranked_row_t make_row(input logic [STATUS_W-1:0] status,
                                             input logic [ADDR_W-1:0] address,
                                             input int unsigned hits, input int rank,
                                             input logic last);
        ranked_row_t r;
        r.status  = status;
        r.address = address;
        r.hits    = OUT_HITS_W'(hits);
        r.rank    = RANK_W'(rank);
        r.last    = last;
        return r;
    endfunction

    function automatic directed_row_t dir_row(input logic [CMD_W-1:0] cmd,
                                              input logic [ADDR_W-1:0] address,
                                              input logic [TOPC_W-1:0] top_count,
                                              input logic typed,
                                              input logic [STATUS_W-1:0] status,
                                              input logic [ADDR_W-1:0] exp_addr,
                                              input int unsigned exp_hits, input int exp_rank);
        directed_row_t d;
        d.cmd       = cmd;
        d.address   = address;
        d.top_count = top_count;
        d.typed     = typed;
        d.row       = make_row(status, exp_addr, exp_hits, exp_rank, 1'b1);
        return d;
    endfunction

    // append one owed result at the tail of the queue
    function automatic void owe_row(input ranked_row_t r);
        awaited_rows.insert(awaited_rows.size(), r);
    endfunction

    // apply one accepted command to the table copy and queue what it must return
    task automatic rank_table_update(input logic [CMD_W-1:0] cmd,
                                     input logic [ADDR_W-1:0] address,
                                     input logic [TOPC_W-1:0] top_count);
        int                pos;
        int                n;
        logic [ADDR_W-1:0] a;
        int unsigned       h;
        pos = -1;
        if (cmd == CMD_INC)
        begin
            for (int i = 0; i < ranked_fill; i++)
                if (pos < 0 && ranked_addr[i] == address)
                    pos = i;
            if (pos < 0 && ranked_fill == TABLE_DEPTH)
            begin
                // full table, new address dropped
                owe_row(make_row(STAT_FULL, address, 0, 0, 1'b1));
                return;
            end
            if (pos < 0)
            begin
                pos = ranked_fill;
                ranked_addr[pos] = address;
                ranked_hits[pos] = 1;
                ranked_fill++;
            end
            else if (ranked_hits[pos] < HIT_MAX)
                ranked_hits[pos]++;
            a = ranked_addr[pos];
            h = ranked_hits[pos];
            // move forward while the predecessor ranks lower
            while (pos > 0 && (ranked_hits[pos-1] < h ||
                               (ranked_hits[pos-1] == h && ranked_addr[pos-1] > a)))
            begin
                ranked_addr[pos] = ranked_addr[pos-1];
                ranked_hits[pos] = ranked_hits[pos-1];
                pos--;
            end
            ranked_addr[pos] = a;
            ranked_hits[pos] = h;
            owe_row(make_row(STAT_OK, a, h, pos, 1'b1));
        end
        else if (cmd == CMD_TOP)
        begin
            n = int'(top_count);
            if (n > ranked_fill)
                n = ranked_fill;
            if (n > MAX_RESULTS)
                n = MAX_RESULTS;
            if (n == 0)
                owe_row(make_row(STAT_EMPTY, '0, 0, 0, 1'b1));
            for (int i = 0; i < n; i++)
                owe_row(make_row(STAT_OK, ranked_addr[i], ranked_hits[i], i,
                                 i == n - 1));
        end
        else if (cmd == CMD_CLEAR)
            ranked_fill = 0;
    endtask

    // drive one command; returns at the edge where it was taken
    task automatic offer_item(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] address,
                              input logic [TOPC_W-1:0] top_count);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.cmd       <= cmd;
        req_ch.node_address <= address;
        req_ch.top_count <= top_count;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        rank_table_update(cmd, address, top_count);
        if (cmd != CMD_UNUSED)
            items_sent++;
    endtask

    // stop offering until the block has returned everything owed
    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_rows.size() != 0);
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t mismatch on %s: expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // response side: random ready, a forced long hold-off on request, field checks
    initial
    begin : response_side
        int          hold_left;
        int          hold_seen;
        ranked_row_t want;
        hold_left = 0;
        hold_seen = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                if (awaited_rows.size() == 0)
                begin
                    $display("%0t unexpected item: status %0d address %h hits %0d rank %0d",
                             $time, rsp_ch.status, rsp_ch.out_address, rsp_ch.out_hits,
                             rsp_ch.rank);
                    mismatches++;
                end
                else
                begin
                    want = awaited_rows.pop_front();
                    check_field("status", 32'(want.status), 32'(rsp_ch.status));
                    check_field("out_address", 32'(want.address), 32'(rsp_ch.out_address));
                    check_field("out_hits", 32'(want.hits), 32'(rsp_ch.out_hits));
                    check_field("rank", 32'(want.rank), 32'(rsp_ch.rank));
                    check_field("last", 32'(want.last), 32'(rsp_ch.last));
                    rows_checked++;
                    if (want.status == STAT_FULL)
                        drops_seen++;
                    if (int'(want.hits) > peak_hits)
                        peak_hits = int'(want.hits);
                end
            end
            if (hold_seen != hold_asks)
            begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // hard stop if the block hangs
    initial
    begin
        #100_000_000;
        $display("timeout with %0d results still owed", awaited_rows.size());
        $display("[frequency_ranked_address_table] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        logic [ADDR_W-1:0] pool [40];
        logic [ADDR_W-1:0] base;
        int                pool_size;
        int                ops;
        int                pick;
        int                roll;
        int                episode;
        int                random_start;

        mismatches   = 0;
        items_sent   = 0;
        rows_checked = 0;
        drops_seen   = 0;
        peak_hits    = 0;
        calm         = 1'b0;
        hold_asks    = 0;
        ranked_fill  = 0;

        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.cmd          <= CMD_INC;
        req_ch.node_address <= '0;
        req_ch.top_count    <= '0;

        // directed part: empty reads, address extremes, ties, clear over stale memory
        directed_rows = '{
            dir_row(CMD_TOP,    16'h0000, 6'd5,  1'b1, STAT_EMPTY, 16'h0000, 0, 0),
            dir_row(CMD_INC,    16'h0000, 6'd0,  1'b1, STAT_OK,    16'h0000, 1, 0),
            dir_row(CMD_INC,    16'hFFFF, 6'd63, 1'b1, STAT_OK,    16'hFFFF, 1, 1),
            dir_row(CMD_INC,    16'hFFFF, 6'd0,  1'b1, STAT_OK,    16'hFFFF, 2, 0),
            dir_row(CMD_TOP,    16'h0000, 6'd0,  1'b1, STAT_EMPTY, 16'h0000, 0, 0),
            dir_row(CMD_TOP,    16'h0000, 6'd63, 1'b0, STAT_OK,    16'h0000, 0, 0),
            dir_row(CMD_UNUSED, 16'h5A5A, 6'd1,  1'b0, STAT_OK,    16'h0000, 0, 0),
            dir_row(CMD_INC,    16'h1234, 6'd0,  1'b0, STAT_OK,    16'h0000, 0, 0),
            dir_row(CMD_INC,    16'h1234, 6'd0,  1'b0, STAT_OK,    16'h0000, 0, 0),
            dir_row(CMD_INC,    16'h0000, 6'd0,  1'b0, STAT_OK,    16'h0000, 0, 0),
            dir_row(CMD_TOP,    16'h0000, 6'd32, 1'b0, STAT_OK,    16'h0000, 0, 0),
            dir_row(CMD_TOP,    16'h0000, 6'd2,  1'b0, STAT_OK,    16'h0000, 0, 0),
            dir_row(CMD_CLEAR,  16'h0000, 6'd0,  1'b0, STAT_OK,    16'h0000, 0, 0),
            dir_row(CMD_TOP,    16'h0000, 6'd1,  1'b1, STAT_EMPTY, 16'h0000, 0, 0),
            dir_row(CMD_INC,    16'h8001, 6'd0,  1'b1, STAT_OK,    16'h8001, 1, 0),
            dir_row(CMD_INC,    16'h7FFE, 6'd0,  1'b1, STAT_OK,    16'h7FFE, 1, 0),
            dir_row(CMD_TOP,    16'h0000, 6'd33, 1'b0, STAT_OK,    16'h0000, 0, 0),
            dir_row(CMD_CLEAR,  16'h0000, 6'd0,  1'b0, STAT_OK,    16'h0000, 0, 0)
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_DIRECTED; r++)
        begin
            offer_item(directed_rows[r].cmd, directed_rows[r].address,
                       directed_rows[r].top_count);
            // rows with a typed expectation replace the predicted one
            if (directed_rows[r].typed)
            begin
                void'(awaited_rows.pop_back());
                owe_row(directed_rows[r].row);
            end
        end

        // random part, in episodes over small address pools so counts build up
        random_start = items_sent;
        episode = 0;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            if (episode == 0)
            begin
                // distinct pool larger than the table
                pool_size = 36;
                base = ADDR_W'($urandom);
                for (int i = 0; i < pool_size; i++)
                    pool[i] = base + ADDR_W'(i * 1237);
                for (int i = 0; i < pool_size; i++)
                    offer_item(CMD_INC, pool[i], TOPC_W'($urandom));
                // long hold-off on a full read while commands keep coming
                hold_asks++;
                offer_item(CMD_TOP, ADDR_W'($urandom), TOPC_W'(40));
                for (int i = 0; i < 6; i++)
                    offer_item(CMD_INC, pool[i], TOPC_W'($urandom));
                wait_for_results();
            end
            else
            begin
                pool_size = ($urandom_range(99) < 70) ? $urandom_range(12, 3)
                                                      : $urandom_range(40, 20);
                for (int i = 0; i < pool_size; i++)
                    pool[i] = ADDR_W'($urandom);
                if ($urandom_range(3) == 0)
                    pool[0] = '0;
                if ($urandom_range(3) == 0)
                    pool[pool_size-1] = '1;
            end

            ops = $urandom_range(60, 20);
            for (int k = 0; k < ops; k++)
            begin
                // a stretch with no idling on either side
                calm = (items_sent - random_start >= 200) && (items_sent - random_start < 300);
                roll = $urandom_range(99);
                if (roll < 72)
                begin
                    // skewed pick so a few addresses dominate
                    pick = $urandom_range($urandom_range(pool_size - 1), 0);
                    offer_item(CMD_INC, pool[pick], TOPC_W'($urandom));
                end
                else if (roll < 88)
                begin
                    if ($urandom_range(1) == 0)
                        offer_item(CMD_TOP, ADDR_W'($urandom),
                                   TOPC_W'($urandom_range(ranked_fill + 1)));
                    else
                        offer_item(CMD_TOP, ADDR_W'($urandom), TOPC_W'($urandom));
                end
                else if (roll < 94)
                    offer_item(CMD_INC, ADDR_W'($urandom), TOPC_W'($urandom));
                else if (roll < 98)
                    offer_item(CMD_CLEAR, ADDR_W'($urandom), TOPC_W'($urandom));
                else
                    offer_item(CMD_UNUSED, ADDR_W'($urandom), TOPC_W'($urandom));
            end
            if (episode == 0 || $urandom_range(99) < 60)
                offer_item(CMD_CLEAR, ADDR_W'($urandom), TOPC_W'($urandom));
            episode++;
        end
        calm = 1'b0;

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d commands in %0d episodes, %0d result items checked",
                 items_sent, episode, rows_checked);
        $display("full-table drops %0d, highest hit count %0d", drops_seen, peak_hits);
        if (mismatches == 0 && awaited_rows.size() == 0)
            $display("[frequency_ranked_address_table] OK");
        else
            $display("[frequency_ranked_address_table] ERROR");
        $finish;
    end

endmodule
